@@ design/wmss_pkg.sv @@
// ============================================================================
// wmss_pkg: shared types and constants of the window scorer
// field widths of the sample and result beats, mode codes, saturation limits
// ============================================================================
package wmss_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int STD_W       = 24;
    localparam int COUNT_W     = 9;
    localparam int SCORE_W     = 25;

    typedef logic [1:0]                    t_mode;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [STD_W-1:0]              t_std;
    typedef logic [COUNT_W-1:0]            t_count;
    typedef logic [SCORE_W-1:0]            t_score;

    // beat modes; the fourth code is ignored
    localparam t_mode MODE_ADD   = 2'd0;
    localparam t_mode MODE_CLOSE = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;

    localparam t_score SCORE_MAX = '1;
    localparam t_std   STD_MAX   = '1;

endpackage

@@ design/wmss_in_if.sv @@
// ============================================================================
// wmss_in_if: sample channel
// valid/ready handshake carrying mode, sample and target speed
// ============================================================================
interface wmss_in_if;

    logic                valid;
    logic                ready;
    wmss_pkg::t_mode     mode;
    wmss_pkg::t_sample   sample;
    wmss_pkg::t_sample   target_speed;

    modport source (output valid, output mode, output sample, output target_speed,
                    input ready);
    modport sink (input valid, input mode, input sample, input target_speed,
                  output ready);

endinterface

@@ design/wmss_out_if.sv @@
// ============================================================================
// wmss_out_if: result channel
// valid/ready handshake carrying the window statistics and score
// ============================================================================
interface wmss_out_if;

    logic                valid;
    logic                ready;
    wmss_pkg::t_sample   mean_speed;
    wmss_pkg::t_std      std_dev;
    wmss_pkg::t_count    num_samples;
    wmss_pkg::t_score    score;
    logic                is_best;
    logic                overflowed;

    modport source (output valid, output mean_speed, output std_dev,
                    output num_samples, output score, output is_best,
                    output overflowed, input ready);
    modport sink (input valid, input mean_speed, input std_dev,
                  input num_samples, input score, input is_best,
                  input overflowed, output ready);

endinterface

@@ design/wmss_div.sv @@
// ============================================================================
// wmss_div: serial restoring divider
// one quotient bit per cycle; done is high for a single cycle, and o_quot holds the quotient in that cycle and after
// ============================================================================
module wmss_div #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quot, n_quot;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0]   w_part;
    logic [DVS_W+1:0] w_trial;

    // shift in the next dividend bit and try the subtract
    assign w_part  = {r_rem, r_quot[DVD_W-1]};
    assign w_trial = {1'b0, w_part} - {2'b00, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_rem  = '0;
            n_quot = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (w_trial[DVS_W+1]) begin
                n_rem  = w_part[DVS_W-1:0];
                n_quot = {r_quot[DVD_W-2:0], 1'b0};
            end else begin
                n_rem  = w_trial[DVS_W-1:0];
                n_quot = {r_quot[DVD_W-2:0], 1'b1};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ design/wmss_isqrt.sv @@
// ============================================================================
// wmss_isqrt: serial integer square root
// digit-by-digit, one root bit per cycle, floor of the root of RAD_W bits
// ============================================================================
module wmss_isqrt #(
    parameter int RAD_W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RAD_W-1:0]   i_radicand,
    output logic               o_done,
    output logic [RAD_W/2-1:0] o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [REM_W+1:0]  w_cur;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+2:0]  w_sub;

    // bring down two radicand bits, try root*4+1
    assign w_cur   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = (REM_W + 2)'({r_root, 2'b01});
    assign w_sub   = {1'b0, w_cur} - {1'b0, w_trial};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ROOT_W - 1);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = r_rad << 2;
            if (w_sub[REM_W+2]) begin
                n_rem  = w_cur[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end else begin
                n_rem  = w_sub[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ design/window_mean_stddev_scorer_core.sv @@
// ============================================================================
// window_mean_stddev_scorer_core: window mean, sample deviation and score
// add beat: adds the sample, then squares |sample| bit-serially into the sum of squares; a full window drops it
// close beat: mean, sample deviation and score, using up to two 64-bit divides and a 32-bit root
// clear beat: resets the best-score tracker; sync active-low reset empties window and best-score tracker
// ============================================================================
module window_mean_stddev_scorer_core #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wmss_in_if.sink       i_in,
    wmss_out_if.source    o_out
);

    import wmss_pkg::*;

    // widths follow from the window depth
    localparam int CW    = $clog2(MAX_SAMPLES + 1);      // sample counter
    localparam int MAG_W = SAMPLE_BITS - 1 + CW;         // |running sum|
    localparam int SUM_W = MAG_W + 1;                    // signed running sum
    localparam int SQ_W  = 2 * (SAMPLE_BITS - 1) + CW;   // sum of squares
    localparam int NUM_W = 2 * MAG_W;                    // n*sumsq and sum^2
    localparam int DIV_W = 2 * CW;                       // n*(n-1)
    localparam int ERR_W = SAMPLE_BITS + 1;              // |mean - target|
    localparam int TOT_W = ((ERR_W > MAG_W) ? ERR_W : MAG_W) + 1;
    localparam int CE_W  = (CW > COUNT_W) ? CW : COUNT_W;

    // one-hot sequencer
    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SQR      = 11'b000_0000_0010,   // bit-serial square of one sample
        S_DIV_MEAN = 11'b000_0000_0100,   // |sum| / n
        S_MUL_SQ   = 11'b000_0000_1000,   // sum^2
        S_MUL_N    = 11'b000_0001_0000,   // n * sumsq
        S_DIFF     = 11'b000_0010_0000,   // n*sumsq - sum^2
        S_DIV_VAR  = 11'b000_0100_0000,   // / (n*(n-1))
        S_SQRT     = 11'b000_1000_0000,   // floor root
        S_ERR      = 11'b001_0000_0000,   // |mean - target|
        S_SCORE    = 11'b010_0000_0000,   // saturated score
        S_OUT      = 11'b100_0000_0000    // load the result beat
    } t_state;

    t_state r_state, n_state;

    // window accumulators and tracker
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [SQ_W-1:0]         r_sqsum, n_sqsum;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_dropped, n_dropped;
    t_score                  r_best, n_best;
    logic                    r_have_best, n_have_best;

    // close working registers
    t_sample                 r_target, n_target;
    t_sample                 r_mean, n_mean;
    logic [MAG_W-1:0]        r_dev, n_dev;
    logic [ERR_W-1:0]        r_err, n_err;
    t_score                  r_score, n_score;
    logic [NUM_W-1:0]        r_sq, n_sq;
    logic [NUM_W-1:0]        r_num, n_num;
    logic [DIV_W-1:0]        r_nn, n_nn;

    // shift-add multiplier: multiplicand moves left, multiplier bits retire right
    logic [NUM_W-1:0]        r_mcand, n_mcand;
    logic [MAG_W-1:0]        r_mplier, n_mplier;

    // result beat register
    logic                    r_out_valid, n_out_valid;
    t_sample                 r_out_mean, n_out_mean;
    t_std                    r_out_std, n_out_std;
    t_count                  r_out_count, n_out_count;
    t_score                  r_out_score, n_out_score;
    logic                    r_out_best, n_out_best;
    logic                    r_out_ovf, n_out_ovf;

    logic                    w_in_fire;
    logic                    w_out_free;
    logic [SAMPLE_BITS-1:0]  w_smag;
    logic [MAG_W-1:0]        w_sum_mag;
    logic [NUM_W-1:0]        w_acc_base;
    logic [NUM_W-1:0]        w_acc_next;
    logic                    w_mul_last;
    logic [NUM_W:0]          w_diff;
    logic                    w_div_start;
    logic [NUM_W-1:0]        w_div_dvd;
    logic [DIV_W-1:0]        w_div_dvs;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_div_quot;
    logic [SAMPLE_BITS-1:0]  w_mean_q;
    logic                    w_sqrt_start;
    logic                    w_sqrt_done;
    logic [MAG_W-1:0]        w_root;
    logic signed [ERR_W-1:0] w_d1;
    logic signed [ERR_W-1:0] w_d2;
    logic [TOT_W-1:0]        w_total;
    logic                    w_is_best;
    logic [CE_W-1:0]         w_cnt_ext;

    // one beat at a time; the result register frees the input side
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // magnitudes of the incoming sample and of the running sum
    assign w_smag    = i_in.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.sample)
                                                  : SAMPLE_BITS'(i_in.sample);
    assign w_sum_mag = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);

    // shared accumulate adder of the multiplier
    always_comb begin
        case (r_state)
            S_SQR:    w_acc_base = NUM_W'(r_sqsum);
            S_MUL_SQ: w_acc_base = r_sq;
            default:  w_acc_base = r_num;
        endcase
    end

    assign w_acc_next = w_acc_base + (r_mplier[0] ? r_mcand : '0);
    assign w_mul_last = (r_mplier[MAG_W-1:1] == '0);

    // n*sumsq - sum^2 with borrow in the top bit
    assign w_diff = {1'b0, r_num} - {1'b0, r_sq};

    // divider is shared by the mean and the variance
    assign w_div_start = (w_in_fire && i_in.mode == MODE_CLOSE && r_count != '0)
                      || (r_state == S_DIFF && !w_diff[NUM_W]);
    assign w_div_dvd   = (r_state == S_IDLE) ? NUM_W'(w_sum_mag) : w_diff[NUM_W-1:0];
    assign w_div_dvs   = (r_state == S_IDLE) ? DIV_W'(r_count) : r_nn;
    assign w_mean_q    = w_div_quot[SAMPLE_BITS-1:0];

    wmss_div #(
        .DVD_W (NUM_W),
        .DVS_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // root starts straight from the variance quotient
    assign w_sqrt_start = (r_state == S_DIV_VAR) && w_div_done;

    wmss_isqrt #(
        .RAD_W (NUM_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_div_quot),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // both differences side by side, pick the non-negative one
    assign w_d1 = ERR_W'(r_mean) - ERR_W'(r_target);
    assign w_d2 = ERR_W'(r_target) - ERR_W'(r_mean);

    assign w_total   = TOT_W'(r_err) + TOT_W'(r_dev);
    assign w_is_best = !r_have_best || (r_score < r_best);
    assign w_cnt_ext = CE_W'(r_count);

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_sqsum     = r_sqsum;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_best      = r_best;
        n_have_best = r_have_best;
        n_target    = r_target;
        n_mean      = r_mean;
        n_dev       = r_dev;
        n_err       = r_err;
        n_score     = r_score;
        n_sq        = r_sq;
        n_num       = r_num;
        n_nn        = r_nn;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_mean  = r_out_mean;
        n_out_std   = r_out_std;
        n_out_count = r_out_count;
        n_out_score = r_out_score;
        n_out_best  = r_out_best;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    case (i_in.mode)
                        MODE_ADD: begin
                            if (r_count >= CW'(MAX_SAMPLES)) begin
                                // window full: drop and remember it
                                n_dropped = 1'b1;
                            end else begin
                                n_sum    = r_sum + SUM_W'(i_in.sample);
                                n_count  = r_count + 1'b1;
                                n_mcand  = NUM_W'(w_smag);
                                n_mplier = MAG_W'(w_smag);
                                n_state  = S_SQR;
                            end
                        end
                        MODE_CLOSE: begin
                            n_target = i_in.target_speed;
                            n_mean   = '0;
                            n_dev    = '0;
                            // empty window skips straight to the score
                            n_state  = (r_count == '0) ? S_ERR : S_DIV_MEAN;
                        end
                        MODE_CLEAR: begin
                            n_best      = '0;
                            n_have_best = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SQR: begin
                n_sqsum  = w_acc_next[SQ_W-1:0];
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (w_mul_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_MEAN: begin
                if (w_div_done) begin
                    // truncation toward zero: divide magnitudes, restore sign
                    n_mean = r_sum[SUM_W-1] ? t_sample'(-w_mean_q) : t_sample'(w_mean_q);
                    if (r_count >= CW'(2)) begin
                        n_mcand  = NUM_W'(w_sum_mag);
                        n_mplier = w_sum_mag;
                        n_sq     = '0;
                        n_state  = S_MUL_SQ;
                    end else begin
                        // single sample: deviation stays zero
                        n_state = S_ERR;
                    end
                end
            end
            S_MUL_SQ: begin
                n_sq     = w_acc_next;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                if (w_mul_last) begin
                    n_mcand  = NUM_W'(r_sqsum);
                    n_mplier = MAG_W'(r_count);
                    n_num    = '0;
                    n_state  = S_MUL_N;
                end
            end
            S_MUL_N: begin
                n_num    = w_acc_next;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_nn     = DIV_W'(r_count) * DIV_W'(r_count - 1'b1);
                if (w_mul_last) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                // negative numerator gives zero deviation
                n_state = w_diff[NUM_W] ? S_ERR : S_DIV_VAR;
            end
            S_DIV_VAR: begin
                if (w_div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_dev   = w_root;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_err   = w_d1[ERR_W-1] ? ERR_W'(w_d2) : ERR_W'(w_d1);
                n_state = S_SCORE;
            end
            S_SCORE: begin
                n_score = (w_total > TOT_W'(SCORE_MAX)) ? SCORE_MAX
                                                        : w_total[SCORE_W-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_mean;
                    n_out_std   = (r_dev[MAG_W-1:STD_W] != '0) ? STD_MAX
                                                               : r_dev[STD_W-1:0];
                    n_out_count = w_cnt_ext[COUNT_W-1:0];
                    n_out_score = r_score;
                    n_out_best  = w_is_best;
                    n_out_ovf   = r_dropped;
                    if (w_is_best) begin
                        n_best      = r_score;
                        n_have_best = 1'b1;
                    end
                    // window starts over, tracker is kept
                    n_sum     = '0;
                    n_sqsum   = '0;
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_best      <= '0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_sqsum     <= n_sqsum;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_best      <= n_best;
            r_have_best <= n_have_best;
            r_out_valid <= n_out_valid;
        end
        r_target    <= n_target;
        r_mean      <= n_mean;
        r_dev       <= n_dev;
        r_err       <= n_err;
        r_score     <= n_score;
        r_sq        <= n_sq;
        r_num       <= n_num;
        r_nn        <= n_nn;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_out_mean  <= n_out_mean;
        r_out_std   <= n_out_std;
        r_out_count <= n_out_count;
        r_out_score <= n_out_score;
        r_out_best  <= n_out_best;
        r_out_ovf   <= n_out_ovf;
    end

    // result beat
    assign o_out.valid       = r_out_valid;
    assign o_out.mean_speed  = r_out_mean;
    assign o_out.std_dev     = r_out_std;
    assign o_out.num_samples = r_out_count;
    assign o_out.score       = r_out_score;
    assign o_out.is_best     = r_out_best;
    assign o_out.overflowed  = r_out_ovf;

endmodule
